### rtl/rth_pkg.sv
`default_nettype none

package rth_pkg;

    localparam int CHANNEL_BITS_DEF  = 8;
    localparam int FRACTION_BITS_DEF = 16;

    // flags that travel with each request down the divider chain
    typedef struct packed {
        logic valid;
        logic zero;   // gray or black pixel: hue and saturation forced to zero
        logic full;   // smallest channel zero: saturation is all ones
    } t_ctl;

endpackage

`default_nettype wire

### rtl/rth_front.sv
`default_nettype none

module rth_front #(
    parameter int CHANNEL_BITS  = rth_pkg::CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = rth_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic [CHANNEL_BITS-1:0]  i_red,
    input  wire logic [CHANNEL_BITS-1:0]  i_green,
    input  wire logic [CHANNEL_BITS-1:0]  i_blue,
    input  wire logic [CHANNEL_BITS-1:0]  i_alpha,
    output rth_pkg::t_ctl                 o_ctl,
    output logic [CHANNEL_BITS+2:0]       o_rem_h,
    output logic [CHANNEL_BITS+2:0]       o_div_h,
    output logic [FRACTION_BITS-1:0]      o_q_h,
    output logic [CHANNEL_BITS-1:0]       o_rem_s,
    output logic [CHANNEL_BITS-1:0]       o_div_s,
    output logic [FRACTION_BITS-1:0]      o_q_s,
    output logic [CHANNEL_BITS-1:0]       o_value,
    output logic [CHANNEL_BITS-1:0]       o_alpha
);

    localparam int DW = CHANNEL_BITS + 3;

    logic [CHANNEL_BITS-1:0] hi;
    logic [CHANNEL_BITS-1:0] lo;
    logic [CHANNEL_BITS-1:0] chroma;
    logic [DW-1:0]           c_ext;
    logic [DW-1:0]           six_c;
    logic [DW-1:0]           num;

    rth_pkg::t_ctl           r_ctl;
    rth_pkg::t_ctl           n_ctl;
    logic [DW-1:0]           r_rem_h;
    logic [DW-1:0]           r_div_h;
    logic [CHANNEL_BITS-1:0] r_rem_s;
    logic [CHANNEL_BITS-1:0] r_div_s;
    logic [CHANNEL_BITS-1:0] r_value;
    logic [CHANNEL_BITS-1:0] r_alpha;

    always_comb begin
        hi = i_red;
        lo = i_red;
        if (i_green > hi) hi = i_green;
        if (i_blue > hi)  hi = i_blue;
        if (i_green < lo) lo = i_green;
        if (i_blue < lo)  lo = i_blue;
        chroma = hi - lo;
        c_ext  = DW'(chroma);
        six_c  = (c_ext << 2) + (c_ext << 1);

        // modular arithmetic: for nonzero chroma the final sum lands in [0, 6*chroma)
        if (i_red == hi) begin
            if (i_green >= i_blue) begin
                num = DW'(i_green) - DW'(i_blue);
            end else begin
                num = six_c - (DW'(i_blue) - DW'(i_green));
            end
        end else if (i_green == hi) begin
            num = (c_ext << 1) + DW'(i_blue) - DW'(i_red);
        end else begin
            num = (c_ext << 2) + DW'(i_red) - DW'(i_green);
        end

        n_ctl.valid = i_valid;
        n_ctl.zero  = (chroma == '0);
        n_ctl.full  = (chroma == hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_h <= num;
            r_div_h <= six_c;
            r_rem_s <= chroma;
            r_div_s <= hi;
            r_value <= hi;
            r_alpha <= i_alpha;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_rem_h = r_rem_h;
    assign o_div_h = r_div_h;
    assign o_q_h   = '0;
    assign o_rem_s = r_rem_s;
    assign o_div_s = r_div_s;
    assign o_q_s   = '0;
    assign o_value = r_value;
    assign o_alpha = r_alpha;

endmodule

`default_nettype wire

### rtl/rth_cell.sv
`default_nettype none

module rth_cell #(
    parameter int CHANNEL_BITS  = rth_pkg::CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = rth_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire rth_pkg::t_ctl            i_ctl,
    input  wire logic [CHANNEL_BITS+2:0]  i_rem_h,
    input  wire logic [CHANNEL_BITS+2:0]  i_div_h,
    input  wire logic [FRACTION_BITS-1:0] i_q_h,
    input  wire logic [CHANNEL_BITS-1:0]  i_rem_s,
    input  wire logic [CHANNEL_BITS-1:0]  i_div_s,
    input  wire logic [FRACTION_BITS-1:0] i_q_s,
    input  wire logic [CHANNEL_BITS-1:0]  i_value,
    input  wire logic [CHANNEL_BITS-1:0]  i_alpha,
    output rth_pkg::t_ctl                 o_ctl,
    output logic [CHANNEL_BITS+2:0]       o_rem_h,
    output logic [CHANNEL_BITS+2:0]       o_div_h,
    output logic [FRACTION_BITS-1:0]      o_q_h,
    output logic [CHANNEL_BITS-1:0]       o_rem_s,
    output logic [CHANNEL_BITS-1:0]       o_div_s,
    output logic [FRACTION_BITS-1:0]      o_q_s,
    output logic [CHANNEL_BITS-1:0]       o_value,
    output logic [CHANNEL_BITS-1:0]       o_alpha
);

    localparam int DW = CHANNEL_BITS + 3;

    logic [DW:0]             t_h;
    logic [CHANNEL_BITS:0]   t_s;
    logic                    bit_h;
    logic                    bit_s;
    logic [DW-1:0]           n_rem_h;
    logic [CHANNEL_BITS-1:0] n_rem_s;

    rth_pkg::t_ctl             r_ctl;
    logic [DW-1:0]             r_rem_h;
    logic [DW-1:0]             r_div_h;
    logic [FRACTION_BITS-1:0]  r_q_h;
    logic [CHANNEL_BITS-1:0]   r_rem_s;
    logic [CHANNEL_BITS-1:0]   r_div_s;
    logic [FRACTION_BITS-1:0]  r_q_s;
    logic [CHANNEL_BITS-1:0]   r_value;
    logic [CHANNEL_BITS-1:0]   r_alpha;

    // one restoring step per divider: a remainder that starts below the divisor stays below it
    always_comb begin
        t_h   = {i_rem_h, 1'b0};
        bit_h = (t_h >= {1'b0, i_div_h});
        n_rem_h = bit_h ? DW'(t_h - {1'b0, i_div_h}) : DW'(t_h);

        t_s   = {i_rem_s, 1'b0};
        bit_s = (t_s >= {1'b0, i_div_s});
        n_rem_s = bit_s ? CHANNEL_BITS'(t_s - {1'b0, i_div_s})
                        : CHANNEL_BITS'(t_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_h <= n_rem_h;
            r_div_h <= i_div_h;
            r_q_h   <= {i_q_h[FRACTION_BITS-2:0], bit_h};
            r_rem_s <= n_rem_s;
            r_div_s <= i_div_s;
            r_q_s   <= {i_q_s[FRACTION_BITS-2:0], bit_s};
            r_value <= i_value;
            r_alpha <= i_alpha;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_rem_h = r_rem_h;
    assign o_div_h = r_div_h;
    assign o_q_h   = r_q_h;
    assign o_rem_s = r_rem_s;
    assign o_div_s = r_div_s;
    assign o_q_s   = r_q_s;
    assign o_value = r_value;
    assign o_alpha = r_alpha;

endmodule

`default_nettype wire

### rtl/rth_skid.sv
`default_nettype none

module rth_skid #(
    parameter int WIDTH = 2 * rth_pkg::FRACTION_BITS_DEF + 2 * rth_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_stall,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full
);

    logic             r_out_valid;
    logic             r_spare_valid;
    logic [WIDTH-1:0] r_out;
    logic [WIDTH-1:0] r_spare;
    logic             out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_spare_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid   <= r_spare_valid || i_push;
            r_spare_valid <= 1'b0;
        end else if (i_push) begin
            r_spare_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_spare_valid) begin
                r_out <= r_spare;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_spare <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_full  = r_spare_valid;

endmodule

`default_nettype wire

### rtl/rgb_to_hsv.sv
// rgb_to_hsv: one pixel per clock unless stalled; each request passes through
// (front stage, one divider cell per hue and saturation bit, output register)
// throughput is one request per cycle unless stalled; the cells set the latency
// a two-entry output buffer keeps the chain moving while one result waits
// reset (i_rst_n low, synchronous) clears all valid flags; payload is not reset
`default_nettype none

module rgb_to_hsv #(
    parameter int CHANNEL_BITS  = rth_pkg::CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = rth_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [CHANNEL_BITS-1:0]  i_red,
    input  wire logic [CHANNEL_BITS-1:0]  i_green,
    input  wire logic [CHANNEL_BITS-1:0]  i_blue,
    input  wire logic [CHANNEL_BITS-1:0]  i_alpha,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [FRACTION_BITS-1:0]      o_hue,
    output logic [FRACTION_BITS-1:0]      o_saturation,
    output logic [CHANNEL_BITS-1:0]       o_value,
    output logic [CHANNEL_BITS-1:0]       o_alpha_out
);

    localparam int DW    = CHANNEL_BITS + 3;
    localparam int NS    = FRACTION_BITS + 1;
    localparam int WIDTH = 2 * FRACTION_BITS + 2 * CHANNEL_BITS;

    rth_pkg::t_ctl             s_ctl   [NS];
    logic [DW-1:0]             s_rem_h [NS];
    logic [DW-1:0]             s_div_h [NS];
    logic [FRACTION_BITS-1:0]  s_q_h   [NS];
    logic [CHANNEL_BITS-1:0]   s_rem_s [NS];
    logic [CHANNEL_BITS-1:0]   s_div_s [NS];
    logic [FRACTION_BITS-1:0]  s_q_s   [NS];
    logic [CHANNEL_BITS-1:0]   s_value [NS];
    logic [CHANNEL_BITS-1:0]   s_alpha [NS];

    logic                      en;
    logic                      full;
    logic                      push;
    logic [FRACTION_BITS-1:0]  hue;
    logic [FRACTION_BITS-1:0]  sat;
    logic [WIDTH-1:0]          out_data;

    assign en      = !full;
    assign o_stall = full;

    rth_front #(
        .CHANNEL_BITS  (CHANNEL_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .i_alpha (i_alpha),
        .o_ctl   (s_ctl[0]),
        .o_rem_h (s_rem_h[0]),
        .o_div_h (s_div_h[0]),
        .o_q_h   (s_q_h[0]),
        .o_rem_s (s_rem_s[0]),
        .o_div_s (s_div_s[0]),
        .o_q_s   (s_q_s[0]),
        .o_value (s_value[0]),
        .o_alpha (s_alpha[0])
    );

    for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_cell
        rth_cell #(
            .CHANNEL_BITS  (CHANNEL_BITS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (s_ctl[k]),
            .i_rem_h (s_rem_h[k]),
            .i_div_h (s_div_h[k]),
            .i_q_h   (s_q_h[k]),
            .i_rem_s (s_rem_s[k]),
            .i_div_s (s_div_s[k]),
            .i_q_s   (s_q_s[k]),
            .i_value (s_value[k]),
            .i_alpha (s_alpha[k]),
            .o_ctl   (s_ctl[k+1]),
            .o_rem_h (s_rem_h[k+1]),
            .o_div_h (s_div_h[k+1]),
            .o_q_h   (s_q_h[k+1]),
            .o_rem_s (s_rem_s[k+1]),
            .o_div_s (s_div_s[k+1]),
            .o_q_s   (s_q_s[k+1]),
            .o_value (s_value[k+1]),
            .o_alpha (s_alpha[k+1])
        );
    end

    // gray pixels give zero, a zero smallest channel saturates
    always_comb begin
        hue = s_ctl[NS-1].zero ? '0 : s_q_h[NS-1];
        if (s_ctl[NS-1].zero) begin
            sat = '0;
        end else if (s_ctl[NS-1].full) begin
            sat = '1;
        end else begin
            sat = s_q_s[NS-1];
        end
    end

    assign push     = s_ctl[NS-1].valid && en;
    assign out_data = {hue, sat, s_value[NS-1], s_alpha[NS-1]};

    rth_skid #(
        .WIDTH (WIDTH)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (out_data),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  ({o_hue, o_saturation, o_value, o_alpha_out}),
        .o_full  (full)
    );

endmodule

`default_nettype wire

### rtl/rth_checker.sv
`default_nettype none

module rth_checker #(
    parameter int CHANNEL_BITS  = rth_pkg::CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = rth_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic                     o_stall,
    input  wire logic [CHANNEL_BITS-1:0]  i_red,
    input  wire logic [CHANNEL_BITS-1:0]  i_green,
    input  wire logic [CHANNEL_BITS-1:0]  i_blue,
    input  wire logic [CHANNEL_BITS-1:0]  i_alpha,
    input  wire logic                     o_valid,
    input  wire logic                     i_stall,
    input  wire logic [FRACTION_BITS-1:0] o_hue,
    input  wire logic [FRACTION_BITS-1:0] o_saturation,
    input  wire logic [CHANNEL_BITS-1:0]  o_value,
    input  wire logic [CHANNEL_BITS-1:0]  o_alpha_out
);

    // a stalled result stays presented
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_hue) && $stable(o_saturation)
                               && $stable(o_value) && $stable(o_alpha_out))
        else $error("stalled result changed");

    // input back-pressure only when the output buffer holds a result
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    // black pixel has no hue or saturation
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_value == '0 |-> o_hue == '0 && o_saturation == '0)
        else $error("black pixel with hue or saturation");

endmodule

bind rgb_to_hsv rth_checker #(
    .CHANNEL_BITS  (CHANNEL_BITS),
    .FRACTION_BITS (FRACTION_BITS)
) u_rth_checker (.*);

`default_nettype wire
